// ===== rtl/c7s_pkg.sv =====
// Package for the seven-segment character encoder: segment tables, character
// codes, the job and encoding structs and the character encoding function.
// Depends on nothing; the encoder modules and the testbench import it.
package c7s_pkg;

  localparam logic [7:0] DOT_BIT     = 8'h80;
  localparam logic [7:0] PERIOD_CODE = 8'h2E;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_W      = 8'h57;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CHAR_QUEST  = 8'h3F;
  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [7:0] SEG_BLANK   = 8'h00;
  localparam logic [7:0] SEG_QUEST   = 8'hA3;
  localparam logic [7:0] SEG_BANG    = 8'h82;
  localparam logic [7:0] SEG_DASH    = 8'h40;
  localparam logic [7:0] SEG_M_FIRST = 8'h33;
  localparam logic [7:0] SEG_M_SEC   = 8'h27;
  localparam logic [7:0] SEG_W_FIRST = 8'h3C;
  localparam logic [7:0] SEG_W_SEC   = 8'h1E;

  localparam logic [7:0] DIGIT_CODES [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // M and W entries are never read; those letters take two bytes.
  localparam logic [7:0] LETTER_CODES [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
    8'h76, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h3E, 8'h00, 8'h76, 8'h6E, 8'h5B
  };

  // Up to two characters to encode for one input item. The first is always
  // present when valid is set; only the first can carry the decimal point.
  typedef struct packed {
    logic       valid;
    logic [7:0] c0;
    logic       dot0;
    logic       c1v;
    logic [7:0] c1;
    logic       last;
  } job_t;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } enc_t;

  function automatic enc_t encode_char(input logic [7:0] ch, input logic dot);
    logic [7:0] up;
    logic [7:0] dp;
    enc_t       e;
    up = ch;
    dp = dot ? DOT_BIT : 8'h00;
    e  = '{two: 1'b0, b0: SEG_BLANK, b1: SEG_BLANK};
    if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
      up = ch - CASE_OFFSET;
    end
    if (up >= CHAR_0 && up <= CHAR_9) begin
      e.b0 = DIGIT_CODES[4'(up - CHAR_0)] | dp;
    end else if (up == CHAR_M) begin
      e.two = 1'b1;
      e.b0  = SEG_M_FIRST;
      e.b1  = SEG_M_SEC | dp;
    end else if (up == CHAR_W) begin
      e.two = 1'b1;
      e.b0  = SEG_W_FIRST;
      e.b1  = SEG_W_SEC | dp;
    end else if (up >= CHAR_A && up <= CHAR_Z) begin
      e.b0 = LETTER_CODES[5'(up - CHAR_A)] | dp;
    end else if (up == CHAR_QUEST) begin
      e.b0 = SEG_QUEST;
    end else if (up == CHAR_BANG) begin
      e.b0 = SEG_BANG;
    end else if (up == CHAR_DASH) begin
      e.b0 = SEG_DASH;
    end
    return e;
  endfunction

endpackage

// ===== rtl/c7s_char_if.sv =====
// Character channel: valid/ready handshake carrying one ASCII character and
// its end-of-string flag. No dependencies.
interface c7s_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/c7s_seg_if.sv =====
// Segment channel: valid/ready handshake carrying one segment byte and its
// end-of-string flag. No dependencies.
interface c7s_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_byte;
  logic       last_byte;

  modport source (output valid, output segment_byte, output last_byte, input ready);
  modport sink   (input valid, input segment_byte, input last_byte, output ready);
endinterface

// ===== rtl/char_to_seven_segment_stream.sv =====
// Top level of the seven-segment character encoder stream.
// Instantiates c7s_hold and c7s_emit; uses c7s_pkg and the c7s_char_if and
// c7s_seg_if channel interfaces.
//
// Usage: ASCII characters of a string enter on in_ch, one item per handshake,
// with end_of_text set on the last character. Segment bytes in gfedcba order,
// bit 7 the decimal point, leave on out_ch; last_byte marks the final byte
// of a string. One character is held back so that a following period can
// light its decimal point; the last character of a string flushes it.
// Letters ignore case, M and W take two bytes, and a lone period is blank.
//
// The job of an item is registered when the item is accepted, and its first
// byte then moves into the output register. Throughput is set by the byte
// sequencer in c7s_emit, which sends one byte per cycle while the receiver
// takes them: an item that causes at most one byte is taken every cycle, and
// an item that causes more (up to four, a held M or W followed by a final M
// or W) keeps the next item waiting until its last byte is sent.
//
// When the receiver stalls, the output register holds its byte and the job
// register holds the next one; items are still taken until one loads the
// job register, and only then does in_ch.ready fall. Reset (rst_n low,
// synchronous) empties the held character, the job and output registers.
module char_to_seven_segment_stream (
  input  logic   clk,
  input  logic   rst_n,
  c7s_char_if.sink   in_ch,
  c7s_seg_if.source  out_ch
);
  import c7s_pkg::*;

  job_t job;
  logic job_ready;
  logic accept;

  // An item is taken whenever the emit stage can load a new job; items that
  // cause no byte still move the held character.
  assign in_ch.ready = job_ready;
  assign accept      = in_ch.valid && job_ready;

  c7s_hold u_hold (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_ch.char_code),
    .end_of_text (in_ch.end_of_text),
    .job         (job)
  );

  // Gate the job with the input valid so that only accepted items load.
  job_t job_gated;
  always_comb begin
    job_gated       = job;
    job_gated.valid = job.valid && in_ch.valid;
  end

  c7s_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_in    (job_gated),
    .job_ready (job_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.segment_byte),
    .out_last  (out_ch.last_byte)
  );

endmodule

// ===== rtl/c7s_hold.sv =====
// Hold stage: keeps the character held back for a possible period and turns
// each accepted item into an encoding job. Depends on c7s_pkg.
module c7s_hold (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          end_of_text,
  output c7s_pkg::job_t job
);
  import c7s_pkg::*;

  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;

  always_comb begin
    job            = '0;
    job.last       = end_of_text;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    if (held_valid_r && char_code == PERIOD_CODE) begin
      // The period merges into the held character.
      job.valid      = 1'b1;
      job.c0         = held_char_r;
      job.dot0       = 1'b1;
      held_valid_nxt = 1'b0;
      held_char_nxt  = 8'h00;
    end else begin
      if (held_valid_r) begin
        job.valid = 1'b1;
        job.c0    = held_char_r;
        job.c1    = char_code;
        job.c1v   = end_of_text;
      end else begin
        job.valid = end_of_text;
        job.c0    = char_code;
      end
      held_valid_nxt = !end_of_text;
      held_char_nxt  = end_of_text ? 8'h00 : char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= 8'h00;
      held_valid_r <= 1'b0;
    end else if (accept) begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_text |=> !held_valid_r)
    else $error("character still held after end of string");
  a_job_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept && held_valid_r |-> job.valid && job.c0 == held_char_r)
    else $error("held character not released into a job");
  a_period_merges: assert property (@(posedge clk) disable iff (!rst_n)
    accept && held_valid_r && char_code == PERIOD_CODE |-> job.dot0 && !job.c1v)
    else $error("period after a held character did not merge");
`endif

endmodule

// ===== rtl/c7s_emit.sv =====
// Emit stage: job register, byte sequencer and output register; depends on
// c7s_pkg. Sends a job's one to four segment bytes, one per unstalled cycle.
module c7s_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  c7s_pkg::job_t job_in,
  output logic          job_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import c7s_pkg::*;

  job_t       job_r;
  logic       job_vld_r;
  logic       sel_r;
  logic       half_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  enc_t       enc;
  logic [7:0] cur_char;
  logic       cur_dot;
  logic       char_done;
  logic       job_done;
  logic       can_emit;
  logic       job_load;

  always_comb begin
    cur_char  = sel_r ? job_r.c1 : job_r.c0;
    cur_dot   = sel_r ? 1'b0 : job_r.dot0;
    enc       = encode_char(cur_char, cur_dot);
    char_done = !enc.two || half_r;
    job_done  = char_done && (sel_r || !job_r.c1v);
    can_emit  = job_vld_r && (!out_valid_r || out_ready);
    job_ready = !job_vld_r || (can_emit && job_done);
    job_load  = job_in.valid && job_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r   <= 1'b0;
      sel_r       <= 1'b0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (job_load) begin
        job_vld_r <= 1'b1;
        sel_r     <= 1'b0;
        half_r    <= 1'b0;
      end else if (can_emit) begin
        if (job_done) begin
          job_vld_r <= 1'b0;
          sel_r     <= 1'b0;
          half_r    <= 1'b0;
        end else if (char_done) begin
          sel_r  <= 1'b1;
          half_r <= 1'b0;
        end else begin
          half_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
    if (can_emit) begin
      out_byte_r <= half_r ? enc.b1 : enc.b0;
      out_last_r <= job_done && job_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !job_vld_r |-> !sel_r && !half_r)
    else $error("sequencer position left over without a job");
  a_sel_second: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r && sel_r |-> job_r.c1v)
    else $error("second character selected but not present");
  a_half_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld_r && half_r |-> enc.two)
    else $error("second byte of a one-byte character");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Regression for char_to_seven_segment_stream: a hand-written table of
// strings, then random strings and noise, checked against a local encoder.
// Depends on the RTL package c7s_pkg and the c7s_char_if/c7s_seg_if channels.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c7s_pkg::*;

  localparam int RANDOM_ITEMS = 175;
  localparam int CYCLE_LIMIT  = 250_000;
  localparam int DRAIN_CYCLES = 20;

  // One segment byte as it should leave the block.
  typedef struct packed {
    logic [7:0] seg;
    logic       last;
  } seg_item_t;

  // One row of the directed table. Where hand is set, count and seg give the
  // bytes typed in from the encoding rules; otherwise the encoder below
  // predicts them. The last flag of a typed row falls on its final byte
  // when eot is set.
  typedef struct packed {
    logic [7:0]      ch;
    logic            eot;
    logic            hand;
    logic [2:0]      count;
    logic [0:3][7:0] seg;
  } char_row_t;

  localparam int DIRECTED_COUNT = 25;
  localparam char_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{"0",   1'b1, 1'b1, 3'd1, 32'h3F00_0000},  // one-digit string after reset
    '{"9",   1'b0, 1'b1, 3'd0, 32'h0000_0000},  // held back, nothing yet
    '{".",   1'b1, 1'b1, 3'd1, 32'hEF00_0000},  // period lights the 9's point
    '{".",   1'b0, 1'b1, 3'd0, 32'h0000_0000},  // lone period is held
    '{".",   1'b0, 1'b1, 3'd1, 32'h0000_0000},  // period after period: blank
    '{"?",   1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{".",   1'b1, 1'b1, 3'd1, 32'hA300_0000},  // ? refuses the point
    '{"M",   1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{"w",   1'b1, 1'b1, 3'd4, 32'h3327_3C1E},  // held M plus final W: four bytes
    '{"m",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{".",   1'b1, 1'b1, 3'd2, 32'h33A7_0000},  // M puts the point on byte two
    '{"!",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{"-",   1'b0, 1'b1, 3'd1, 32'h8200_0000},
    '{8'hFF, 1'b0, 1'b1, 3'd1, 32'h4000_0000},
    '{8'h00, 1'b0, 1'b1, 3'd1, 32'h0000_0000},  // unknown high code is blank
    '{".",   1'b1, 1'b1, 3'd1, 32'h0000_0000},  // unknown code refuses the point
    '{"a",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{"Z",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{"z",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{8'h80, 1'b0, 1'b1, 3'd1, 32'h5B00_0000},
    '{".",   1'b0, 1'b1, 3'd1, 32'h0000_0000},
    '{"W",   1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{".",   1'b0, 1'b1, 3'd2, 32'h3C9E_0000},
    '{"@",   1'b0, 1'b0, 3'd0, 32'h0000_0000},  // just below the letter range
    '{".",   1'b1, 1'b0, 3'd0, 32'h0000_0000}
  };

  // Segment patterns in gfedcba order, written out independently of the RTL.
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] LETTER_GLYPH [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
    8'h76, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h3E, 8'h00, 8'h76, 8'h6E, 8'h5B
  };

  logic clk;
  logic rst_n;

  c7s_char_if in_ch ();
  c7s_seg_if  out_ch ();

  char_to_seven_segment_stream DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Encoder state mirrored from the block: the character held back while the
  // next one is awaited, in case that one is a period.
  logic [7:0] held_char;
  logic       held_valid;

  seg_item_t  seg_expect_q [$];   // bytes still owed by the block, oldest first
  seg_item_t  fresh_q [$];        // bytes just predicted for one character

  // When idle_on is clear, neither side inserts gaps, so back-to-back
  // traffic gets exercised in stretches.
  bit idle_on;

  int err_count;
  int items_sent;
  int strings_sent;
  int bytes_checked;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every input of the block starts from a known value.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // Adds the byte(s) of one character to fresh_q. The decimal point goes on
  // the last byte of a character, and only letters and digits accept it.
  // Upper and lower case encode alike.
  function automatic void push_glyph(input logic [7:0] ch, input logic dot,
                                     input logic last);
    logic [7:0] up;
    logic [7:0] dp;
    up = (ch >= "a" && ch <= "z") ? ch - 8'h20 : ch;
    dp = dot ? 8'h80 : 8'h00;
    if (up >= "0" && up <= "9") begin
      fresh_q.push_back('{DIGIT_GLYPH[4'(up - "0")] | dp, last});
    end else if (up == "M") begin
      fresh_q.push_back('{8'h33, 1'b0});
      fresh_q.push_back('{8'h27 | dp, last});
    end else if (up == "W") begin
      fresh_q.push_back('{8'h3C, 1'b0});
      fresh_q.push_back('{8'h1E | dp, last});
    end else if (up >= "A" && up <= "Z") begin
      fresh_q.push_back('{LETTER_GLYPH[5'(up - "A")] | dp, last});
    end else if (up == "?") begin
      fresh_q.push_back('{8'hA3, last});
    end else if (up == "!") begin
      fresh_q.push_back('{8'h82, last});
    end else if (up == "-") begin
      fresh_q.push_back('{8'h40, last});
    end else begin
      // Everything else, a lone period included, shows nothing.
      fresh_q.push_back('{8'h00, last});
    end
  endfunction

  // Advances the mirrored state by one accepted character and leaves the
  // bytes it releases in fresh_q. A period right after a held character is
  // absorbed as that character's decimal point; anything else pushes out the
  // held character and takes its place. End of text flushes what is held.
  function automatic void predict_segments(input logic [7:0] ch, input logic eot);
    fresh_q.delete();
    if (held_valid && ch == ".") begin
      push_glyph(held_char, 1'b1, eot);
      held_valid = 1'b0;
      held_char  = 8'h00;
    end else begin
      if (held_valid) begin
        push_glyph(held_char, 1'b0, 1'b0);
      end
      held_char  = ch;
      held_valid = 1'b1;
      if (eot) begin
        push_glyph(ch, 1'b0, 1'b1);
        held_valid = 1'b0;
        held_char  = 8'h00;
      end
    end
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Characters that make up readable text, with periods common enough to
  // merge often, plus an occasional arbitrary code.
  function automatic logic [7:0] pick_text_char();
    int         r;
    logic [7:0] case_bit;
    r        = $urandom_range(0, 99);
    case_bit = $urandom_range(0, 1) ? 8'h20 : 8'h00;
    if (r < 22) begin
      return ".";
    end else if (r < 34) begin
      return ($urandom_range(0, 1) ? "M" : "W") | case_bit;
    end else if (r < 60) begin
      return ("A" + 8'($urandom_range(0, 25))) | case_bit;
    end else if (r < 80) begin
      return "0" + 8'($urandom_range(0, 9));
    end else if (r < 90) begin
      case ($urandom_range(0, 2))
        0: return "?";
        1: return "!";
        default: return "-";
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one character after a random gap and holds it until the block
  // takes it. Typed bytes, where given, stand in for the prediction, but the
  // mirrored state advances either way.
  task automatic send_char(input logic [7:0] ch, input logic eot,
                           input logic hand, input logic [2:0] count,
                           input logic [0:3][7:0] seg);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.char_code   = ch;
    in_ch.end_of_text = eot;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_segments(ch, eot);
    if (hand) begin
      for (int k = 0; k < count; k++) begin
        seg_expect_q.push_back('{seg[k], eot && (k == count - 1)});
      end
    end else begin
      foreach (fresh_q[k]) begin
        seg_expect_q.push_back(fresh_q[k]);
      end
    end
    items_sent++;
    if (eot) begin
      strings_sent++;
    end
  endtask

  // Receiver: ready drops for stalls of random length while idling is on.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        r            = $urandom_range(0, 99);
        stall_left   = (r < 70) ? 0 : (r < 92) ? $urandom_range(1, 4)
                                               : $urandom_range(10, 40);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Every byte the block hands over must match the oldest one owed, field by
  // field; a byte with nothing owed is an error in itself.
  always @(posedge clk) begin
    seg_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (seg_expect_q.size() == 0) begin
        $display("%0t: unexpected segment byte %02h (last %0b)", $time,
                 out_ch.segment_byte, out_ch.last_byte);
        err_count++;
      end else begin
        want = seg_expect_q.pop_front();
        if (out_ch.segment_byte !== want.seg) begin
          $display("%0t: segment_byte mismatch: expected %02h, actual %02h",
                   $time, want.seg, out_ch.segment_byte);
          err_count++;
        end
        if (out_ch.last_byte !== want.last) begin
          $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                   $time, want.last, out_ch.last_byte);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d bytes still owed", $time, seg_expect_q.size());
    $display("char_to_seven_segment_stream regression: fail");
    $finish;
  end

  initial begin
    int         len;
    bit         noise;
    logic [7:0] ch;
    held_char     = 8'h00;
    held_valid    = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    strings_sent  = 0;
    bytes_checked = 0;
    idle_on       = 1'b1;

    // Synchronous reset, released on a falling edge.
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: extremes of the code range, every symbol class, merges,
    // lone and doubled periods, and the four-byte M/W case.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].eot, DIRECTED_ROWS[i].hand,
                DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].seg);
    end

    // Random part: mostly well-formed strings ending in end_of_text, with
    // some noise bursts of arbitrary codes and flags in between. Idling is
    // switched per string so that some stretches run back to back.
    while (items_sent < DIRECTED_COUNT + RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      noise   = ($urandom_range(0, 4) == 0);
      len     = noise ? $urandom_range(1, 6) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          ch = 8'($urandom_range(0, 255));
          send_char(ch, 1'($urandom_range(0, 1)), 1'b0, 3'd0, '0);
        end else begin
          ch = pick_text_char();
          send_char(ch, i == len - 1, 1'b0, 3'd0, '0);
        end
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Let the receiver drain whatever is owed, then watch a little longer
    // for stray bytes.
    while (seg_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d terminated strings; %0d segment bytes checked.",
             items_sent, strings_sent, bytes_checked);
    $display("Errors found: %0d", err_count);
    if (err_count == 0) begin
      $display("char_to_seven_segment_stream regression: pass");
    end else begin
      $display("char_to_seven_segment_stream regression: fail");
    end
    $finish;
  end

endmodule
